// ===== hdl/tps_pkg.sv =====
package tps_pkg;

    // Field widths fixed by the item format.
    localparam int unsigned MIN_W  = 14;
    localparam int unsigned DAY_W  = 3;
    localparam int unsigned HOUR_W = 5;
    localparam int unsigned MN_W   = 6;
    localparam int unsigned MODE_W = 2;
    localparam int unsigned PH_W   = 2;

    // Configuration register file.
    localparam int unsigned CFG_COUNT = 7;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_W     = 14;

    localparam logic [CFG_IDX_W-1:0] CFG_WINTER_PUMP1  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINTER_PAUSE1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINTER_PUMP2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WINTER_PAUSE2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SUMMER_PUMP1  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SUMMER_PAUSE1 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SUMMER_PUMP2  = 3'd6;

    // Operating modes.
    localparam logic [MODE_W-1:0] MODE_MANUAL = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WINTER = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SUMMER = 2'd2;

    // Cycle phases.
    localparam logic [PH_W-1:0] PH_PUMP1  = 2'd0;
    localparam logic [PH_W-1:0] PH_PAUSE1 = 2'd1;
    localparam logic [PH_W-1:0] PH_PUMP2  = 2'd2;
    localparam logic [PH_W-1:0] PH_PAUSE2 = 2'd3;

    // Summer end of the second pause: Wednesday at noon.
    localparam logic [DAY_W-1:0]  WEDNESDAY = 3'd3;
    localparam logic [HOUR_W-1:0] NOON_HOUR = 5'd12;

    typedef logic [CFG_COUNT-1:0][CFG_W-1:0] cfg_t;

    typedef struct packed {
        logic [MIN_W-1:0]  minute_of_week;
        logic [DAY_W-1:0]  weekday;
        logic [HOUR_W-1:0] hour;
        logic [MN_W-1:0]   minute;
        logic              night_line;
        logic              button_pump1;
        logic              button_pump2;
        logic              mode_advance;
        logic [MIN_W-1:0]  service_wait_minutes;
    } in_word_t;

    typedef struct packed {
        logic              pump1_on;
        logic              pump2_on;
        logic [PH_W-1:0]   phase;
        logic [MODE_W-1:0] op_mode;
        logic [MIN_W-1:0]  left_pump1;
        logic [MIN_W-1:0]  left_pause1;
        logic [MIN_W-1:0]  left_pump2;
        logic [MIN_W-1:0]  left_pause2;
    } out_word_t;

endpackage

// ===== hdl/tps_if.sv =====
// Input channel: one control tick per word.
interface tps_in_if;
    import tps_pkg::*;

    logic     valid;
    logic     ready;
    in_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// Output channel: one status word per tick.
interface tps_out_if;
    import tps_pkg::*;

    logic      valid;
    logic      ready;
    out_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/tps_core.sv =====
module tps_core #(
    parameter int unsigned WEEK_MINUTES = 10080
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step_en,
    input  tps_pkg::cfg_t      cfg,
    input  tps_pkg::in_word_t  item,
    output tps_pkg::out_word_t result
);
    import tps_pkg::*;

    localparam logic [MIN_W-1:0] LAST_MINUTE = MIN_W'(WEEK_MINUTES - 1);

    // Sequencer state.
    logic [PH_W-1:0]             phase_reg, phase_next;
    logic [MODE_W-1:0]           mode_reg, mode_next;
    logic [MODE_W-1:0]           last_mode_reg, last_mode_next;
    logic                        summer_sel_reg, summer_sel_next;
    logic                        pending_reg, pending_next;
    logic [3:0][MIN_W-1:0]       remaining_reg, remaining_next;
    logic [PH_W-1:0]             cidx_reg, cidx_next;
    logic [MIN_W-1:0]            next_minute_reg, next_minute_next;
    logic [1:0]                  pump_reg, pump_next;

    // Working values of the tick.
    logic [MIN_W-1:0]  armed_minute;
    logic              noon_wed;
    logic              mode_changed;
    logic [PH_W-1:0]   phase_a;
    logic              pending_a;
    logic [MIN_W-1:0]  rem_cur;
    logic              step_phase;
    logic [PH_W-1:0]   ph;
    logic [PH_W-1:0]   ph_prev;
    logic [MIN_W-1:0]  load_val;
    logic              minute_hit;
    logic              off_common;
    logic              p1;
    logic              p2;

    // Minute that the week clock must reach for the next decrement.
    assign armed_minute = (item.minute_of_week == LAST_MINUTE) ? '0
                        : item.minute_of_week + 1'b1;
    assign noon_wed = (item.weekday == WEDNESDAY) && (item.hour == NOON_HOUR)
                   && (item.minute == '0);

    // Mode step, table select and phase advance.
    always_comb
    begin
        mode_next = mode_reg;
        if (item.mode_advance)
        begin
            case (mode_reg)
                MODE_MANUAL: mode_next = MODE_WINTER;
                MODE_WINTER: mode_next = MODE_SUMMER;
                MODE_SUMMER: mode_next = MODE_MANUAL;
                default:     mode_next = mode_reg;
            endcase
        end

        mode_changed    = (mode_next != last_mode_reg);
        last_mode_next  = mode_next;
        summer_sel_next = summer_sel_reg;
        phase_a         = phase_reg;
        pending_a       = pending_reg;
        if (mode_changed)
        begin
            if (mode_next == MODE_SUMMER)
            begin
                summer_sel_next = 1'b1;
            end
            if (mode_next == MODE_WINTER || mode_next == MODE_MANUAL)
            begin
                summer_sel_next = 1'b0;
            end
            // Entering manual forces one advance.
            if (mode_next == MODE_MANUAL)
            begin
                phase_a   = phase_reg + 1'b1;
                pending_a = 1'b1;
            end
        end

        // Regular transition test on the budget being counted.
        rem_cur = remaining_reg[cidx_reg];
        if (phase_a != PH_PAUSE2)
        begin
            step_phase = (rem_cur == '0);
        end
        else
        begin
            step_phase = ((rem_cur == '0) && (mode_next == MODE_WINTER))
                      || (noon_wed && (mode_next == MODE_SUMMER));
        end
        ph = step_phase ? phase_a + 1'b1 : phase_a;
        ph_prev = ph - 1'b1;
        pending_next = 1'b0;
    end

    // Entry load and per-minute countdown on the four budgets.
    always_comb
    begin
        if (ph == PH_PAUSE2 && mode_next == MODE_SUMMER)
        begin
            load_val = item.service_wait_minutes;
        end
        else if (summer_sel_next && ph != PH_PAUSE2)
        begin
            load_val = cfg[CFG_SUMMER_PUMP1 + CFG_IDX_W'(ph)];
        end
        else
        begin
            load_val = cfg[CFG_IDX_W'(ph)];
        end

        remaining_next   = remaining_reg;
        cidx_next        = cidx_reg;
        next_minute_next = next_minute_reg;
        if (pending_a || step_phase)
        begin
            remaining_next[ph_prev] = '0;
            remaining_next[ph]      = load_val;
            cidx_next               = ph;
            next_minute_next        = armed_minute;
        end

        minute_hit = (item.minute_of_week == next_minute_next);
        if (minute_hit && remaining_next[cidx_next] != '0)
        begin
            remaining_next[cidx_next] = remaining_next[cidx_next] - 1'b1;
        end
        if (minute_hit)
        begin
            next_minute_next = armed_minute;
        end
    end

    // Pump rules; off wins over on, no rule keeps the level.
    always_comb
    begin
        off_common = (mode_next == MODE_WINTER && item.night_line)
                  || (mode_next != MODE_MANUAL && (ph == PH_PAUSE1 || ph == PH_PAUSE2));
        p1 = pump_reg[0];
        p2 = pump_reg[1];
        if ((!item.night_line && mode_next == MODE_WINTER && ph == PH_PUMP1)
            || (mode_next == MODE_SUMMER && ph == PH_PUMP1)
            || (mode_next == MODE_MANUAL && item.button_pump1))
        begin
            p1 = 1'b1;
        end
        if (off_common || (mode_next == MODE_MANUAL && !item.button_pump1))
        begin
            p1 = 1'b0;
        end
        if ((!item.night_line && mode_next == MODE_WINTER && ph == PH_PUMP2)
            || (mode_next == MODE_SUMMER && ph == PH_PUMP2)
            || (mode_next == MODE_MANUAL && item.button_pump2))
        begin
            p2 = 1'b1;
        end
        if (off_common || (mode_next == MODE_MANUAL && !item.button_pump2))
        begin
            p2 = 1'b0;
        end
        pump_next = {p2, p1};
        phase_next = ph;
    end

    // Status word of this tick.
    always_comb
    begin
        result.pump1_on    = p1;
        result.pump2_on    = p2;
        result.phase       = ph;
        result.op_mode     = mode_next;
        result.left_pump1  = remaining_next[PH_PUMP1];
        result.left_pause1 = remaining_next[PH_PAUSE1];
        result.left_pump2  = remaining_next[PH_PUMP2];
        result.left_pause2 = remaining_next[PH_PAUSE2];
    end

    // State update, one tick per enabled cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_PAUSE2;
            mode_reg        <= MODE_WINTER;
            last_mode_reg   <= MODE_MANUAL;
            summer_sel_reg  <= 1'b0;
            pending_reg     <= 1'b1;
            remaining_reg   <= '0;
            cidx_reg        <= PH_PUMP1;
            next_minute_reg <= '0;
            pump_reg        <= '0;
        end
        else if (step_en)
        begin
            phase_reg       <= phase_next;
            mode_reg        <= mode_next;
            last_mode_reg   <= last_mode_next;
            summer_sel_reg  <= summer_sel_next;
            pending_reg     <= pending_next;
            remaining_reg   <= remaining_next;
            cidx_reg        <= cidx_next;
            next_minute_reg <= next_minute_next;
            pump_reg        <= pump_next;
        end
    end

    // The phase only moves on a tick.
    a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !step_en |=> $stable(phase_reg))
        else $error("phase changed without a tick");

    // Every tick runs any pending entry action.
    a_entry_done: assert property (@(posedge clk) disable iff (!rst_n)
        step_en |=> !pending_reg)
        else $error("entry action left pending after a tick");

    // After a tick the counted budget belongs to the current phase.
    a_count_phase: assert property (@(posedge clk) disable iff (!rst_n)
        step_en |=> (cidx_reg == phase_reg))
        else $error("counted budget does not match phase");

    // The last mode always follows the mode after a tick.
    a_last_mode: assert property (@(posedge clk) disable iff (!rst_n)
        step_en |=> (last_mode_reg == mode_reg))
        else $error("last mode not tracking mode");

endmodule

// ===== hdl/two_pump_phase_sequencer_top.sv =====
// Two pump phase sequencer.
// din carries one control tick per word: week clock, weekday and time, night
// line, pump buttons, mode advance pulse and the summer service wait. dout
// returns one status word per tick: pump levels, phase, mode and the four
// remaining minute budgets. Both channels use a valid/ready handshake.
// The seven table registers are written through cfg_we, cfg_index and
// cfg_data; the user must write them only while no tick is in flight, which
// the block itself does not enforce. An index past the table is ignored.
// A word taken on din lands in an input register, is processed by the
// sequencer once the output register can take its result, and its status
// word leaves from the output register. One word is accepted every cycle as
// long as dout is taken; the single sequencer step per cycle sets that rate.
// When dout stalls, the input register still takes one more word, then
// din.ready drops until the output register drains.
// Reset starts in winter mode at the second pause with every budget at zero,
// both pumps off, the tables cleared and both pipeline registers empty.
module two_pump_phase_sequencer_top #(
    parameter int unsigned WEEK_MINUTES = 10080
) (
    input  logic                             clk,
    input  logic                             rst_n,
    tps_in_if.sink                           din,
    tps_out_if.source                        dout,
    input  logic                             cfg_we,
    input  logic [tps_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tps_pkg::CFG_W-1:0]        cfg_data
);
    import tps_pkg::*;

    cfg_t      cfg_reg;
    in_word_t  in_word_reg;
    logic      in_valid_reg;
    out_word_t out_word_reg;
    logic      out_valid_reg;
    out_word_t step_result;
    logic      step_en;
    logic      out_free;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we && cfg_index < CFG_IDX_W'(CFG_COUNT))
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    // Handshake: the step runs when the output register can take its word.
    assign out_free = !out_valid_reg || dout.ready;
    assign step_en  = in_valid_reg && out_free;
    assign din.ready = !in_valid_reg || out_free;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (din.ready)
        begin
            in_valid_reg <= din.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (din.valid && din.ready)
        begin
            in_word_reg <= din.data;
        end
    end

    tps_core #(
        .WEEK_MINUTES (WEEK_MINUTES)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .cfg     (cfg_reg),
        .item    (in_word_reg),
        .result  (step_result)
    );

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            out_word_reg <= step_result;
        end
    end

    assign dout.valid = out_valid_reg;
    assign dout.data  = out_word_reg;

    // An empty input register always takes a word.
    a_in_open: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> din.ready)
        else $error("input register empty but not ready");

    // A word in the input register moves on when the output is empty.
    a_move_on: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("word stuck in input register");

    // An accepted word is held in the input register.
    a_capture: assert property (@(posedge clk) disable iff (!rst_n)
        (din.valid && din.ready) |=> in_valid_reg)
        else $error("accepted word lost");

endmodule

// ===== dv/pump_sequence_checker.sv =====
`timescale 1ns / 100ps
module pump_sequence_checker #(
    parameter int unsigned WEEK_MINUTES = 10080
) (
    input  logic                          clk,
    input  logic                          rst_n,
    tps_in_if                             din,
    tps_out_if                            dout,
    input  logic                          cfg_we,
    input  logic [tps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tps_pkg::CFG_W-1:0]     cfg_data,
    output int                            mismatches,
    output int                            outstanding
);
    import tps_pkg::*;

    // Mirror of the budget tables as written through the configuration port.
    logic [CFG_W-1:0] table_min [CFG_COUNT];

    // Sequencer state as the block should hold it.
    logic [PH_W-1:0]   phase_q;
    logic [MODE_W-1:0] mode_q;
    logic [MODE_W-1:0] seen_mode;
    logic              summer_sel;
    logic              entry_due;
    logic [MIN_W-1:0]  left_min [4];
    logic [PH_W-1:0]   count_idx;
    logic [MIN_W-1:0]  due_minute;
    logic              level1;
    logic              level2;

    // Status words still owed by the block, oldest first.
    out_word_t due_status [$];

    int fail_total = 0;
    int owed_total = 0;

    assign mismatches  = fail_total;
    assign outstanding = owed_total;

    // Return the sequencer and the tables to their state after reset.
    function automatic void clear_sequence();
        for (int i = 0; i < CFG_COUNT; i++)
        begin
            table_min[i] = '0;
        end
        for (int i = 0; i < 4; i++)
        begin
            left_min[i] = '0;
        end
        phase_q    = PH_PAUSE2;
        mode_q     = MODE_WINTER;
        seen_mode  = MODE_MANUAL;
        summer_sel = 1'b0;
        entry_due  = 1'b1;
        count_idx  = PH_PUMP1;
        due_minute = '0;
        level1     = 1'b0;
        level2     = 1'b0;
    endfunction

    // The minute at which the next countdown step is due.
    function automatic logic [MIN_W-1:0] minute_after(input logic [MIN_W-1:0] now);
        if (int'(now) == int'(WEEK_MINUTES) - 1)
            return '0;
        return now + 1'b1;
    endfunction

    function automatic void next_phase();
        entry_due = 1'b1;
        phase_q   = phase_q + 1'b1;
    endfunction

    // Budget loaded on entry to a phase from the selected table.
    function automatic logic [MIN_W-1:0] load_budget(input logic [PH_W-1:0] ph);
        if (summer_sel && ph != PH_PAUSE2)
            return table_min[CFG_SUMMER_PUMP1 + CFG_IDX_W'(ph)];
        return table_min[CFG_IDX_W'(ph)];
    endfunction

    // One control tick: mode step, phase step, entry action, countdown and
    // pump rules, giving the status word the block has to return.
    function automatic out_word_t step_pump_sequence(input in_word_t w);
        logic [MIN_W-1:0] now;
        logic [PH_W-1:0]  ph;
        logic [PH_W-1:0]  prev_ph;
        logic             noon_wed;
        logic             off_common;
        logic             p1;
        logic             p2;
        out_word_t        r;

        now      = w.minute_of_week;
        noon_wed = (w.weekday == WEDNESDAY) && (w.hour == NOON_HOUR) && (w.minute == '0);

        if (w.mode_advance)
        begin
            case (mode_q)
                MODE_MANUAL: mode_q = MODE_WINTER;
                MODE_WINTER: mode_q = MODE_SUMMER;
                MODE_SUMMER: mode_q = MODE_MANUAL;
                default: ;
            endcase
        end

        // A mode change picks the table; entering manual forces an advance.
        if (mode_q != seen_mode)
        begin
            seen_mode = mode_q;
            if (mode_q == MODE_SUMMER)
                summer_sel = 1'b1;
            if (mode_q == MODE_WINTER)
                summer_sel = 1'b0;
            if (mode_q == MODE_MANUAL)
            begin
                summer_sel = 1'b0;
                next_phase();
            end
        end

        if (left_min[count_idx] == '0 && phase_q != PH_PAUSE2)
            next_phase();
        else if (phase_q == PH_PAUSE2 &&
                 ((left_min[count_idx] == '0 && mode_q == MODE_WINTER) ||
                  (noon_wed && mode_q == MODE_SUMMER)))
            next_phase();

        // Entry action: clear the previous budget and load this one.
        ph = phase_q;
        if (entry_due)
        begin
            entry_due         = 1'b0;
            prev_ph           = ph - 1'b1;
            left_min[prev_ph] = '0;
            if (ph == PH_PAUSE2 && mode_q == MODE_SUMMER)
                left_min[ph] = w.service_wait_minutes;
            else
                left_min[ph] = load_budget(ph);
            count_idx  = ph;
            due_minute = minute_after(now);
        end

        // Count down once per new minute; zero stays zero.
        if (now == due_minute)
        begin
            if (left_min[count_idx] != '0)
                left_min[count_idx] = left_min[count_idx] - 1'b1;
            due_minute = minute_after(now);
        end

        // Pump rules: an off rule wins over an on rule, otherwise levels hold.
        p1 = level1;
        p2 = level2;
        off_common = (mode_q == MODE_WINTER && w.night_line) ||
                     (mode_q != MODE_MANUAL && (ph == PH_PAUSE1 || ph == PH_PAUSE2));
        if ((!w.night_line && mode_q == MODE_WINTER && ph == PH_PUMP1) ||
            (mode_q == MODE_SUMMER && ph == PH_PUMP1) ||
            (mode_q == MODE_MANUAL && w.button_pump1))
            p1 = 1'b1;
        if (off_common || (mode_q == MODE_MANUAL && !w.button_pump1))
            p1 = 1'b0;
        if ((!w.night_line && mode_q == MODE_WINTER && ph == PH_PUMP2) ||
            (mode_q == MODE_SUMMER && ph == PH_PUMP2) ||
            (mode_q == MODE_MANUAL && w.button_pump2))
            p2 = 1'b1;
        if (off_common || (mode_q == MODE_MANUAL && !w.button_pump2))
            p2 = 1'b0;
        level1 = p1;
        level2 = p2;

        r.pump1_on    = p1;
        r.pump2_on    = p2;
        r.phase       = ph;
        r.op_mode     = mode_q;
        r.left_pump1  = left_min[PH_PUMP1];
        r.left_pause1 = left_min[PH_PAUSE1];
        r.left_pump2  = left_min[PH_PUMP2];
        r.left_pause2 = left_min[PH_PAUSE2];
        return r;
    endfunction

    function automatic void check_field(input string label, input logic [MIN_W-1:0] want,
                                        input logic [MIN_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
            fail_total++;
        end
    endfunction

    // Watch both channels and the configuration port on every rising edge.
    always @(posedge clk or negedge rst_n)
    begin : watch
        out_word_t want;

        if (!rst_n)
        begin
            clear_sequence();
            due_status.delete();
        end
        else
        begin
            if (cfg_we && cfg_index < CFG_COUNT)
                table_min[cfg_index] = cfg_data;

            // Compare a returned word before taking a new tick in.
            if (dout.valid && dout.ready)
            begin
                if (due_status.size() == 0)
                begin
                    $display("%0t: status word %h arrived with no tick waiting",
                             $time, dout.data);
                    fail_total++;
                end
                else
                begin
                    want = due_status.pop_front();
                    check_field("pump1_on", MIN_W'(want.pump1_on),
                                MIN_W'(dout.data.pump1_on));
                    check_field("pump2_on", MIN_W'(want.pump2_on),
                                MIN_W'(dout.data.pump2_on));
                    check_field("phase", MIN_W'(want.phase), MIN_W'(dout.data.phase));
                    check_field("op_mode", MIN_W'(want.op_mode), MIN_W'(dout.data.op_mode));
                    check_field("left_pump1", want.left_pump1, dout.data.left_pump1);
                    check_field("left_pause1", want.left_pause1, dout.data.left_pause1);
                    check_field("left_pump2", want.left_pump2, dout.data.left_pump2);
                    check_field("left_pause2", want.left_pause2, dout.data.left_pause2);
                end
            end

            if (din.valid && din.ready)
                due_status.push_back(step_pump_sequence(din.data));
        end
        owed_total = due_status.size();
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
module testbench;
    import tps_pkg::*;

    localparam int unsigned WEEK_MINUTES = 10080;
    localparam int DAY_MINUTES      = 1440;
    localparam int HOUR_MINUTES     = 60;
    localparam int WED_NOON         = (int'(WEDNESDAY) - 1) * DAY_MINUTES +
                                      int'(NOON_HOUR) * HOUR_MINUTES;
    localparam int ROUNDS           = 6;
    localparam int TICKS_PER_ROUND  = 72;
    localparam int LONG_HOLD        = 150;
    localparam int QUIET_LIMIT      = 2000;
    localparam logic [CFG_IDX_W-1:0] CFG_STRAY = CFG_IDX_W'(CFG_COUNT);

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    int                   mismatches;
    int                   outstanding;

    // Long receiver hold-offs asked by the stimulus and carried out by the sink.
    int hold_asked  = 0;
    int hold_served = 0;

    // Table contents for the next configuration phase.
    logic [CFG_W-1:0] plan [CFG_COUNT];

    tps_in_if  din ();
    tps_out_if dout ();

    two_pump_phase_sequencer_top #(
        .WEEK_MINUTES (WEEK_MINUTES)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .din       (din),
        .dout      (dout),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pump_sequence_checker #(
        .WEEK_MINUTES (WEEK_MINUTES)
    ) status_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .din         (din),
        .dout        (dout),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Gap before the next word: mostly none or short, a few long.
    function automatic int pick_gap(input bit steady);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // A tick whose weekday and time of day agree with the week minute.
    function automatic in_word_t clock_word(input int m);
        in_word_t w;
        w = '0;
        w.minute_of_week = MIN_W'(m);
        w.weekday        = DAY_W'(m / DAY_MINUTES + 1);
        w.hour           = HOUR_W'((m % DAY_MINUTES) / HOUR_MINUTES);
        w.minute         = MN_W'(m % HOUR_MINUTES);
        return w;
    endfunction

    // Offer one word and return at the edge that takes it.
    task automatic send_tick(input in_word_t w);
        din.data  <= w;
        din.valid <= 1'b1;
        do
            @(negedge clk);
        while (!din.ready);
        @(posedge clk);
    endtask

    task automatic rest_input(input int cycles);
        if (cycles > 0)
        begin
            din.valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Stop offering and wait until every owed status word has come back.
    task automatic drain_results();
        din.valid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
        @(posedge clk);
    endtask

    // Write the planned tables, optionally followed by a write past the table.
    task automatic load_tables(input bit with_stray);
        for (int i = 0; i < CFG_COUNT; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= plan[i];
            @(posedge clk);
        end
        if (with_stray)
        begin
            cfg_index <= CFG_STRAY;
            cfg_data  <= '1;
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // Short directed run over mode changes, week wrap, noon and field extremes.
    task automatic directed_ticks();
        in_word_t w;

        w = clock_word(0);
        send_tick(w);
        w = clock_word(1);
        w.night_line = 1'b1;
        send_tick(w);
        w = clock_word(2);
        send_tick(w);
        rest_input(pick_gap(1'b0));
        w = clock_word(3);
        send_tick(w);
        w = clock_word(int'(WEEK_MINUTES) - 1);
        send_tick(w);
        w = clock_word(0);
        send_tick(w);
        // Into summer, then the Wednesday noon end of the second pause.
        w = clock_word(1);
        w.mode_advance         = 1'b1;
        w.service_wait_minutes = 14'd2;
        send_tick(w);
        w = clock_word(WED_NOON);
        send_tick(w);
        w = clock_word(WED_NOON + 1);
        send_tick(w);
        rest_input(pick_gap(1'b0));
        // Into manual, with every button combination.
        w = clock_word(WED_NOON + 2);
        w.mode_advance = 1'b1;
        send_tick(w);
        w = clock_word(WED_NOON + 3);
        w.button_pump1 = 1'b1;
        send_tick(w);
        w = clock_word(WED_NOON + 4);
        w.button_pump2 = 1'b1;
        send_tick(w);
        w = clock_word(WED_NOON + 5);
        w.button_pump1 = 1'b1;
        w.button_pump2 = 1'b1;
        send_tick(w);
        w = clock_word(WED_NOON + 6);
        w.mode_advance = 1'b1;
        w.night_line   = 1'b1;
        send_tick(w);
        // Field extremes beyond their meaningful ranges.
        w = '1;
        w.mode_advance = 1'b0;
        send_tick(w);
        w = '0;
        send_tick(w);
        w = '0;
        w.weekday      = WEDNESDAY;
        w.hour         = NOON_HOUR;
        w.mode_advance = 1'b1;
        send_tick(w);
        w = clock_word(5);
        w.service_wait_minutes = '1;
        send_tick(w);
        w = clock_word(6);
        w.mode_advance = 1'b1;
        w.button_pump1 = 1'b1;
        w.button_pump2 = 1'b1;
        send_tick(w);
        w = clock_word(7);
        w.mode_advance = 1'b1;
        send_tick(w);
    endtask

    // Mostly a running week clock with random controls, some raw noise words.
    task automatic random_ticks(input int count, input bit hold_first);
        in_word_t    w;
        logic [63:0] raw;
        int          wall;
        int          r;
        bit          night;
        bit          steady;

        wall   = $urandom_range(0, WEEK_MINUTES - 1);
        night  = 1'b0;
        steady = hold_first;
        for (int n = 0; n < count; n++)
        begin
            if (n % 24 == 0 && !(hold_first && n == 0))
                steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 11) == 0)
            begin
                raw = {$urandom, $urandom};
                w   = raw[$bits(in_word_t)-1:0];
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 74)
                    wall = wall + 1;
                else if (r < 94)
                    wall = wall;
                else if (r < 97)
                    wall = WED_NOON - $urandom_range(0, 3);
                else
                    wall = WEEK_MINUTES - $urandom_range(1, 3);
                if (wall >= WEEK_MINUTES)
                    wall = 0;
                if ($urandom_range(0, 7) == 0)
                    night = !night;
                w = clock_word(wall);
                w.night_line   = night;
                w.button_pump1 = 1'($urandom_range(0, 1));
                w.button_pump2 = 1'($urandom_range(0, 1));
                w.mode_advance = ($urandom_range(0, 14) == 0);
                if ($urandom_range(0, 7) == 0)
                    w.service_wait_minutes = MIN_W'($urandom_range(0, 16383));
                else
                    w.service_wait_minutes = MIN_W'($urandom_range(0, 4));
            end
            send_tick(w);
            rest_input(pick_gap(steady));
        end
    endtask

    // Stimulus and verdict.
    initial
    begin
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        din.valid <= 1'b0;
        din.data  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        plan[CFG_WINTER_PUMP1]  = 14'd2;
        plan[CFG_WINTER_PAUSE1] = 14'd1;
        plan[CFG_WINTER_PUMP2]  = 14'd2;
        plan[CFG_WINTER_PAUSE2] = 14'd1;
        plan[CFG_SUMMER_PUMP1]  = 14'd1;
        plan[CFG_SUMMER_PAUSE1] = 14'd1;
        plan[CFG_SUMMER_PUMP2]  = 14'd2;
        load_tables(1'b0);
        directed_ticks();

        for (int round = 0; round < ROUNDS; round++)
        begin
            drain_results();
            for (int i = 0; i < CFG_COUNT; i++)
            begin
                case (round)
                    2:       plan[i] = '0;
                    4:       plan[i] = '1;
                    5:       plan[i] = CFG_W'($urandom_range(0, 5));
                    default: plan[i] = CFG_W'($urandom_range(0, 3));
                endcase
            end
            if (round == 3)
            begin
                plan[CFG_WINTER_PUMP1]  = CFG_W'(WEEK_MINUTES);
                plan[CFG_WINTER_PAUSE1] = 14'd1;
                plan[CFG_WINTER_PUMP2]  = CFG_W'(WEEK_MINUTES);
                plan[CFG_WINTER_PAUSE2] = '0;
                plan[CFG_SUMMER_PUMP1]  = CFG_W'(WEEK_MINUTES);
                plan[CFG_SUMMER_PAUSE1] = '0;
                plan[CFG_SUMMER_PUMP2]  = CFG_W'(WEEK_MINUTES);
            end
            load_tables(round == 3);
            // One round starts with the sink held off while words keep coming.
            if (round == 1)
                hold_asked++;
            random_ticks(TICKS_PER_ROUND, round == 1);
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Result sink: runs of ready and stall, mostly short, sometimes long.
    initial
    begin : result_sink
        int  span;
        int  r;
        bit  level;

        forever
        begin
            if (hold_served != hold_asked)
            begin
                hold_served = hold_asked;
                level       = 1'b0;
                span        = LONG_HOLD;
            end
            else
            begin
                r = $urandom_range(0, 99);
                level = (r < 60);
                if (r < 45)
                    span = $urandom_range(1, 8);
                else if (r < 60)
                    span = $urandom_range(20, 60);
                else if (r < 92)
                    span = $urandom_range(1, 3);
                else
                    span = $urandom_range(10, 40);
            end
            dout.ready <= level;
            repeat (span) @(posedge clk);
        end
    end

    // Watchdog: too many cycles without any word moving ends the run.
    initial
    begin : watchdog
        int quiet;

        quiet = 0;
        forever
        begin
            @(posedge clk);
            if (!rst_n || (din.valid && din.ready) || (dout.valid && dout.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

endmodule

// ===== filelist.f =====
hdl/tps_pkg.sv
hdl/tps_if.sv
hdl/tps_core.sv
hdl/two_pump_phase_sequencer_top.sv
dv/pump_sequence_checker.sv
dv/testbench.sv
